### src/ttrp_pkg.sv
// Shared types, constants and the id table of the telemetry report parser.
// Used by the front parser, the job queue, the back emitter and the top level.
package ttrp_pkg;

	localparam int MaxElements = 5;
	localparam int BufDepth    = 4 * MaxElements;
	localparam int MultiCount  = (5 <= MaxElements) ? 5 : MaxElements;
	localparam int CntW        = $clog2(MultiCount + 1);
	localparam int VcW         = $clog2(BufDepth + 1);
	localparam int BufIdxW     = $clog2(BufDepth);
	localparam int WordIdxW    = $clog2(MaxElements);
	localparam int QueueDepth  = 2;
	localparam int QPtrW       = $clog2(QueueDepth);
	localparam int QCntW       = $clog2(QueueDepth + 1);

	localparam logic [7:0] SubOpcode     = 8'h03;
	localparam logic [7:0] EvTypeReset   = 8'h05;
	localparam logic [7:0] IdEventType   = 8'h01;
	localparam logic [7:0] IdAclHandle   = 8'h4a;
	localparam logic [7:0] IdScoHandle   = 8'h6a;
	localparam logic [7:0] IdWordFirst   = 8'h4b;
	localparam logic [7:0] IdWordLast    = 8'h60;
	localparam logic [7:0] IdScoFirst    = 8'h6b;
	localparam logic [7:0] IdScoLast     = 8'h6e;
	localparam logic [7:0] IdMultiFirst  = 8'h6f;
	localparam logic [7:0] IdMultiLast   = 8'h74;
	localparam logic [7:0] IdTailFirst   = 8'h75;
	localparam logic [7:0] IdTailLast    = 8'h78;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_ID,
		PH_LEN,
		PH_VALUE,
		PH_SKIP
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_OPCODE  = 3'd1,
		ST_UNKNOWN = 3'd2,
		ST_LENGTH  = 3'd3,
		ST_TRUNC   = 3'd4,
		ST_EVTYPE  = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		LINK_NONE = 2'd0,
		LINK_ACL  = 2'd1,
		LINK_SCO  = 2'd2
	} link_t;

	typedef enum logic {
		KIND_ELEMENT = 1'b0,
		KIND_STATUS  = 1'b1
	} kind_t;

	// Element size in bytes (0 for an unknown id) and element count.
	typedef struct packed {
		logic [2:0]      size;
		logic [CntW-1:0] count;
	} tlv_shape_t;

	// One unit of work handed from the parser to the emitter: the elements
	// of a finished TLV, an end-of-report status, or both.
	typedef struct packed {
		logic                      has_elem;
		logic [7:0]                id;
		tlv_shape_t                shape;
		logic [BufDepth-1:0][7:0]  bytes;
		logic                      has_status;
		status_t                   status;
		link_t                     link;
	} job_t;

	function automatic tlv_shape_t lookup(logic [7:0] id);
		tlv_shape_t s;
		s.size  = 3'd0;
		s.count = '0;
		if (id == IdEventType) begin
			s.size  = 3'd1;
			s.count = CntW'(1);
		end else if (id == IdAclHandle || id == IdScoHandle) begin
			s.size  = 3'd2;
			s.count = CntW'(1);
		end else if ((id >= IdWordFirst && id <= IdWordLast) ||
				(id >= IdScoFirst && id <= IdScoLast) ||
				(id >= IdTailFirst && id <= IdTailLast)) begin
			s.size  = 3'd4;
			s.count = CntW'(1);
		end else if (id >= IdMultiFirst && id <= IdMultiLast) begin
			s.size  = 3'd4;
			s.count = CntW'(MultiCount);
		end
		return s;
	endfunction

endpackage

### src/ttrp_if.sv
// Channel interfaces of the telemetry report parser: report bytes in and
// result items out. Depends on nothing but plain logic types.
interface ttrp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source(output valid, output data_byte, output final_byte, input ready);
	modport sink(input valid, input data_byte, input final_byte, output ready);
endinterface

interface ttrp_result_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [7:0]  subevent_id;
	logic [2:0]  element_index;
	logic [31:0] element_value;
	logic [2:0]  report_status;
	logic [1:0]  link_kind;
	logic        is_last;

	modport source(output valid, output result_kind, output subevent_id,
		output element_index, output element_value, output report_status,
		output link_kind, output is_last, input ready);
	modport sink(input valid, input result_kind, input subevent_id,
		input element_index, input element_value, input report_status,
		input link_kind, input is_last, output ready);
endinterface

### src/telemetry_tlv_report_parser.sv
// Top level of the link-quality telemetry report parser: front parser, job
// queue and result emitter. Depends on ttrp_pkg, ttrp_if and the three units.
//
//   Channel   Dir  Handshake      Payload
//   report    in   valid/ready    data_byte[7:0], final_byte
//   result    out  valid/ready    result_kind, subevent_id, element_index,
//                                 element_value, report_status, link_kind, is_last
//   cfg       in   cfg_wen        cfg_wdata[7:0] (event type for id 0x01)
//
// One report byte is taken every cycle while the job queue has room. The
// parser finishes its work on a byte in the cycle it takes it; a finished TLV
// or end of report becomes one job in the two-entry queue.
// The emitter sends one result per cycle from its output register while the
// result channel is ready, so a job with n elements and a status gives n+1
// results; that rate sets how long the queue stays full after a multi-element TLV.
// Input stalls only when both queue entries are held; a stalled result
// register still lets the parser run until the queue fills.
// arst_n clears all framing, error and handshake state at once; the value
// buffer and payload registers are not reset and need no clearing pass.
module telemetry_tlv_report_parser import ttrp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	ttrp_byte_if.sink       report,
	ttrp_result_if.source   result,
	input  logic            cfg_wen,
	input  logic [7:0]      cfg_wdata
);

	logic  fq_push_valid;
	logic  fq_push_ready;
	job_t  fq_push_job;
	logic  fq_pop_valid;
	logic  fq_pop_ready;
	job_t  fq_pop_job;

	// The front end classifies each byte and hands complete work to the queue.
	ttrp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.report    (report),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.job_valid (fq_push_valid),
		.job_ready (fq_push_ready),
		.job       (fq_push_job)
	);

	// The queue decouples the byte-rate front end from result bursts.
	ttrp_job_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_push_valid),
		.push_ready (fq_push_ready),
		.push_job   (fq_push_job),
		.pop_valid  (fq_pop_valid),
		.pop_ready  (fq_pop_ready),
		.pop_job    (fq_pop_job)
	);

	// The back end turns each job into one result per cycle while the result channel is ready.
	ttrp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (fq_pop_valid),
		.job_ready (fq_pop_ready),
		.job       (fq_pop_job),
		.result    (result)
	);

	// A request is only accepted when the queue can hold what it produces.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(report.valid && report.ready) |-> fq_push_ready)
		else $error("report request accepted while the job queue was full");

	// The status result always closes the results of its byte.
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.result_kind == KIND_STATUS) |-> result.is_last)
		else $error("status result without is_last");

	// Element results carry neither a status nor a link kind.
	a_elem_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.result_kind == KIND_ELEMENT) |->
		(result.report_status == ST_OK && result.link_kind == LINK_NONE))
		else $error("element result with status or link fields set");

	// An element never carries an index past the largest element count.
	a_elem_index: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.result_kind == KIND_ELEMENT) |->
		(result.element_index < 3'(MultiCount)))
		else $error("element index out of range");

endmodule

### src/ttrp_front.sv
// Parser front end: takes report bytes, tracks header and TLV framing and
// the sticky error, and pushes jobs. Depends on ttrp_pkg and ttrp_byte_if.
module ttrp_front import ttrp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	ttrp_byte_if.sink        report,
	input  logic             cfg_wen,
	input  logic [7:0]       cfg_wdata,
	output logic             job_valid,
	input  logic             job_ready,
	output job_t             job
);

	phase_t           phase_q, phase_d;
	logic [1:0]       hc_q, hc_d;
	logic [7:0]       tlv_id_q, tlv_id_d;
	logic [7:0]       tlv_len_q, tlv_len_d;
	logic [VcW-1:0]   vc_q, vc_d;
	status_t          err_q, err_d;
	link_t            link_q, link_d;
	logic [7:0]       evtype_q;
	logic [7:0]       buf_q [BufDepth];

	logic                      take;
	logic                      buf_wr;
	logic [BufIdxW-1:0]        wr_idx;
	logic [BufDepth-1:0][7:0]  bytes_v;
	logic [VcW-1:0]            vc_inc;
	tlv_shape_t                shape_b;
	tlv_shape_t                shape_id;
	logic [7:0]                expect_len;
	logic                      err_hit;
	status_t                   err_code;
	logic                      emit;

	assign report.ready = job_ready;
	assign take         = report.valid && job_ready;
	assign wr_idx       = vc_q[BufIdxW-1:0];
	assign vc_inc       = vc_q + VcW'(1);
	assign shape_b      = lookup(report.data_byte);
	assign shape_id     = lookup(tlv_id_q);
	assign expect_len   = 8'(shape_id.size) * 8'(shape_id.count);

	// The buffer as it stands after this byte is written.
	always_comb begin
		for (int i = 0; i < BufDepth; i++) begin
			bytes_v[i] = (buf_wr && wr_idx == BufIdxW'(i)) ? report.data_byte : buf_q[i];
		end
	end

	always_comb begin
		phase_d   = phase_q;
		hc_d      = hc_q;
		tlv_id_d  = tlv_id_q;
		tlv_len_d = tlv_len_q;
		vc_d      = vc_q;
		err_d     = err_q;
		link_d    = link_q;
		buf_wr    = 1'b0;
		err_hit   = 1'b0;
		err_code  = ST_OK;
		emit      = 1'b0;
		if (take) begin
			unique case (phase_q)
				PH_HEADER: begin
					if (hc_q < 2'd2) begin
						hc_d = hc_q + 2'd1;
						if (report.final_byte) begin
							err_hit  = 1'b1;
							err_code = ST_TRUNC;
						end
					end else begin
						hc_d = 2'd0;
						if (report.data_byte != SubOpcode) begin
							err_hit  = 1'b1;
							err_code = ST_OPCODE;
						end else begin
							phase_d = PH_ID;
						end
					end
				end
				PH_ID: begin
					tlv_id_d = report.data_byte;
					if (shape_b.size == 3'd0) begin
						err_hit  = 1'b1;
						err_code = ST_UNKNOWN;
					end else if (report.final_byte) begin
						err_hit  = 1'b1;
						err_code = ST_TRUNC;
					end else begin
						phase_d = PH_LEN;
					end
				end
				PH_LEN: begin
					tlv_len_d = report.data_byte;
					vc_d      = '0;
					if (report.data_byte != expect_len) begin
						err_hit  = 1'b1;
						err_code = ST_LENGTH;
					end else if (report.final_byte) begin
						err_hit  = 1'b1;
						err_code = ST_TRUNC;
					end else begin
						phase_d = PH_VALUE;
					end
				end
				PH_VALUE: begin
					buf_wr = (vc_q < VcW'(BufDepth));
					vc_d   = vc_inc;
					if (8'(vc_inc) >= tlv_len_q) begin
						emit    = 1'b1;
						vc_d    = '0;
						phase_d = PH_ID;
						if (tlv_id_q == IdEventType) begin
							if (bytes_v[0] != evtype_q) begin
								err_hit  = 1'b1;
								err_code = ST_EVTYPE;
							end
						end else if (tlv_id_q == IdAclHandle) begin
							link_d = LINK_ACL;
						end else if (tlv_id_q == IdScoHandle) begin
							link_d = LINK_SCO;
						end
					end else if (report.final_byte) begin
						err_hit  = 1'b1;
						err_code = ST_TRUNC;
					end
				end
				PH_SKIP: begin
				end
				default: begin
				end
			endcase
			// The first error of a report is kept; parsing stops until the end.
			if (err_hit) begin
				if (err_q == ST_OK) begin
					err_d = err_code;
				end
				phase_d = PH_SKIP;
			end
		end

		job.has_elem   = emit;
		job.id         = tlv_id_q;
		job.shape      = shape_id;
		job.bytes      = bytes_v;
		job.has_status = report.final_byte;
		job.status     = err_d;
		job.link       = link_d;
		job_valid      = take && (emit || report.final_byte);

		if (take && report.final_byte) begin
			phase_d   = PH_HEADER;
			hc_d      = 2'd0;
			tlv_id_d  = 8'd0;
			tlv_len_d = 8'd0;
			vc_d      = '0;
			err_d     = ST_OK;
			link_d    = LINK_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hc_q      <= 2'd0;
			tlv_id_q  <= 8'd0;
			tlv_len_q <= 8'd0;
			vc_q      <= '0;
			err_q     <= ST_OK;
			link_q    <= LINK_NONE;
			evtype_q  <= EvTypeReset;
		end else begin
			phase_q   <= phase_d;
			hc_q      <= hc_d;
			tlv_id_q  <= tlv_id_d;
			tlv_len_q <= tlv_len_d;
			vc_q      <= vc_d;
			err_q     <= err_d;
			link_q    <= link_d;
			if (cfg_wen) begin
				evtype_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (buf_wr) begin
			buf_q[wr_idx] <= report.data_byte;
		end
	end

endmodule

### src/ttrp_job_fifo.sv
// Short job queue between parser and emitter, so that each side can stall
// on its own. Depends on ttrp_pkg.
module ttrp_job_fifo import ttrp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  job_t  push_job,
	output logic  pop_valid,
	input  logic  pop_ready,
	output job_t  pop_job
);

	job_t              entry_q [QueueDepth];
	logic [QPtrW-1:0]  wr_ptr_q;
	logic [QPtrW-1:0]  rd_ptr_q;
	logic [QCntW-1:0]  cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (cnt_q != QCntW'(QueueDepth));
	assign pop_valid  = (cnt_q != '0);
	assign pop_job    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QCntW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QCntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

### src/ttrp_back.sv
// Emitter back end: expands each job into its element results, its status
// result or both, one per cycle while the result channel is ready, through an
// output register. Depends on ttrp_pkg and ttrp_result_if.
module ttrp_back import ttrp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_valid,
	output logic            job_ready,
	input  job_t            job,
	ttrp_result_if.source   result
);

	job_t                         job_q;
	logic                         active_q;
	logic [CntW-1:0]              k_q;
	logic                         out_valid_q;
	kind_t                        kind_q;
	logic [7:0]                   id_q;
	logic [2:0]                   index_q;
	logic [31:0]                  value_q;
	status_t                      status_q;
	link_t                        link_q;
	logic                         last_q;

	logic                         adv;
	logic                         in_elem;
	logic                         res_last;
	logic                         load;
	logic [MaxElements-1:0][31:0] words;
	logic [31:0]                  elem_value;

	assign words    = job_q.bytes;
	assign adv      = active_q && (!out_valid_q || result.ready);
	assign in_elem  = job_q.has_elem && (k_q < job_q.shape.count);
	assign res_last = in_elem ?
		((CntW'(k_q + CntW'(1)) == job_q.shape.count) && !job_q.has_status) : 1'b1;
	assign load      = job_valid && (!active_q || (adv && res_last));
	assign job_ready = load;

	always_comb begin
		case (job_q.shape.size)
			3'd1:    elem_value = {24'd0, job_q.bytes[0]};
			3'd2:    elem_value = {16'd0, job_q.bytes[1], job_q.bytes[0]};
			default: elem_value = words[WordIdxW'(k_q)];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				active_q <= 1'b1;
				k_q      <= '0;
			end else if (adv && res_last) begin
				active_q <= 1'b0;
			end else if (adv) begin
				k_q <= k_q + CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= job;
		end
		if (adv) begin
			last_q <= res_last;
			if (in_elem) begin
				kind_q   <= KIND_ELEMENT;
				id_q     <= job_q.id;
				index_q  <= 3'(k_q);
				value_q  <= elem_value;
				status_q <= ST_OK;
				link_q   <= LINK_NONE;
			end else begin
				kind_q   <= KIND_STATUS;
				id_q     <= 8'd0;
				index_q  <= 3'd0;
				value_q  <= 32'd0;
				status_q <= job_q.status;
				link_q   <= job_q.link;
			end
		end
	end

	assign result.valid         = out_valid_q;
	assign result.result_kind   = kind_q;
	assign result.subevent_id   = id_q;
	assign result.element_index = index_q;
	assign result.element_value = value_q;
	assign result.report_status = status_q;
	assign result.link_kind     = link_q;
	assign result.is_last       = last_q;

endmodule

### tb/telemetry_tlv_report_parser_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of telemetry_tlv_report_parser.
// Depends on ttrp_pkg, ttrp_if and the parser's RTL. It drives a short table of reports and
// then random reports, and checks every result against a predictor kept in this module.
module telemetry_tlv_report_parser_test;
	import ttrp_pkg::*;

	// One result as the predictor sees it, in the order of the result channel's fields.
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  id;
		logic [2:0]  index;
		logic [31:0] value;
		status_t     status;
		link_t       link;
		logic        last;
	} parsed_result_t;

	// One report byte as it is offered on the report channel.
	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} report_byte_t;

	// A row of the directed table. Where pinned is set, the row ends a report and its status
	// result is typed in here, not taken from the predictor.
	typedef struct packed {
		logic [7:0] data;
		logic       fin;
		logic       pinned;
		status_t    status;
		link_t      link;
	} script_row_t;

	localparam int ScriptRows = 27;

	// The directed reports. Each one covers a case that is easy to reason about by hand.
	localparam script_row_t ReportScript [ScriptRows] = '{
		// A report that is only the header is fine and leaves the link kind at none.
		'{8'h00, 1'b0, 1'b0, ST_OK, LINK_NONE},
		'{8'h00, 1'b0, 1'b0, ST_OK, LINK_NONE},
		'{SubOpcode, 1'b1, 1'b1, ST_OK, LINK_NONE},
		// The report ends inside the header prefix.
		'{8'hff, 1'b1, 1'b1, ST_TRUNC, LINK_NONE},
		// A wrong sub-opcode on the final byte wins over truncation.
		'{8'h5a, 1'b0, 1'b0, ST_OK, LINK_NONE},
		'{8'ha5, 1'b0, 1'b0, ST_OK, LINK_NONE},
		'{8'h07, 1'b1, 1'b1, ST_OPCODE, LINK_NONE},
		// An unknown id is sticky: the ACL id after it must not count.
		'{8'h00, 1'b0, 1'b0, ST_OK, LINK_NONE},
		'{8'h00, 1'b0, 1'b0, ST_OK, LINK_NONE},
		'{SubOpcode, 1'b0, 1'b0, ST_OK, LINK_NONE},
		'{8'h02, 1'b0, 1'b0, ST_OK, LINK_NONE},
		'{IdAclHandle, 1'b1, 1'b1, ST_UNKNOWN, LINK_NONE},
		// A bad length on the final byte wins over truncation.
		'{8'hff, 1'b0, 1'b0, ST_OK, LINK_NONE},
		'{8'hff, 1'b0, 1'b0, ST_OK, LINK_NONE},
		'{SubOpcode, 1'b0, 1'b0, ST_OK, LINK_NONE},
		'{IdWordFirst, 1'b0, 1'b0, ST_OK, LINK_NONE},
		'{8'h03, 1'b1, 1'b1, ST_LENGTH, LINK_NONE},
		// An SCO handle with the largest two-byte value, then an event type that does not
		// match. The element still comes out, and the status shares the final byte with it.
		'{8'h00, 1'b0, 1'b0, ST_OK, LINK_NONE},
		'{8'h00, 1'b0, 1'b0, ST_OK, LINK_NONE},
		'{SubOpcode, 1'b0, 1'b0, ST_OK, LINK_NONE},
		'{IdScoHandle, 1'b0, 1'b0, ST_OK, LINK_NONE},
		'{8'h02, 1'b0, 1'b0, ST_OK, LINK_NONE},
		'{8'hff, 1'b0, 1'b0, ST_OK, LINK_NONE},
		'{8'hff, 1'b0, 1'b0, ST_OK, LINK_NONE},
		'{IdEventType, 1'b0, 1'b0, ST_OK, LINK_NONE},
		'{8'h01, 1'b0, 1'b0, ST_OK, LINK_NONE},
		'{8'h00, 1'b1, 1'b0, ST_OK, LINK_NONE}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen;
	logic [7:0] cfg_wdata;

	ttrp_byte_if   report_bus();
	ttrp_result_if result_bus();

	telemetry_tlv_report_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.report(report_bus),
		.result(result_bus),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// Predictor state. It mirrors the parser's framing, error and link state, plus the event
	// type register as last written.
	logic [7:0] event_type;
	phase_t     rp_phase;
	int         rp_header;
	logic [7:0] rp_id;
	logic [7:0] rp_length;
	int         rp_filled;
	logic [7:0] rp_bytes [BufDepth];
	status_t    rp_error;
	link_t      rp_link;

	parsed_result_t awaited_results[$];
	int failures = 0;
	int parsed_bytes = 0;
	bit steady_sender = 1'b0;

	// Element size and count of a TLV id. A size of zero marks an id that is not in the table.
	function automatic void tlv_shape(input logic [7:0] id, output int unsigned size,
			output int unsigned count);
		size = 0;
		count = 0;
		if (id == IdEventType) begin
			size = 1;
			count = 1;
		end else if (id == IdAclHandle || id == IdScoHandle) begin
			size = 2;
			count = 1;
		end else if ((id >= IdWordFirst && id <= IdWordLast) ||
				(id >= IdScoFirst && id <= IdScoLast) ||
				(id >= IdTailFirst && id <= IdTailLast)) begin
			size = 4;
			count = 1;
		end else if (id >= IdMultiFirst && id <= IdMultiLast) begin
			size = 4;
			count = MultiCount;
		end
	endfunction

	// Only the first error of a report is kept; the rest of the report is skipped.
	function automatic void flag_error(input status_t code);
		if (rp_error == ST_OK)
			rp_error = code;
		rp_phase = PH_SKIP;
	endfunction

	// Clears everything that a report leaves behind. The event type register is kept.
	function automatic void clear_parse();
		rp_phase = PH_HEADER;
		rp_header = 0;
		rp_id = '0;
		rp_length = '0;
		rp_filled = 0;
		foreach (rp_bytes[i])
			rp_bytes[i] = '0;
		rp_error = ST_OK;
		rp_link = LINK_NONE;
	endfunction

	// Works out the results that one accepted report byte causes and advances the state.
	function automatic void parse_report_byte(input logic [7:0] b, input logic fin,
			ref parsed_result_t outs[$]);
		int unsigned size, count, k, j;
		logic [31:0] word;
		outs.delete();
		case (rp_phase)
			PH_HEADER: begin
				if (rp_header < 2) begin
					rp_header++;
					if (fin)
						flag_error(ST_TRUNC);
				end else begin
					rp_header = 0;
					if (b != SubOpcode)
						flag_error(ST_OPCODE);
					else
						rp_phase = PH_ID;
				end
			end
			PH_ID: begin
				rp_id = b;
				tlv_shape(b, size, count);
				if (size == 0)
					flag_error(ST_UNKNOWN);
				else if (fin)
					flag_error(ST_TRUNC);
				else
					rp_phase = PH_LEN;
			end
			PH_LEN: begin
				tlv_shape(rp_id, size, count);
				rp_length = b;
				rp_filled = 0;
				if (b != size * count)
					flag_error(ST_LENGTH);
				else if (fin)
					flag_error(ST_TRUNC);
				else
					rp_phase = PH_VALUE;
			end
			PH_VALUE: begin
				if (rp_filled < BufDepth)
					rp_bytes[rp_filled] = b;
				rp_filled++;
				if (rp_filled >= rp_length) begin
					// The value is complete: split it into little-endian elements.
					tlv_shape(rp_id, size, count);
					for (k = 0; k < count; k++) begin
						word = '0;
						for (j = 0; j < size; j++)
							if (k * size + j < BufDepth)
								word[8 * j +: 8] = rp_bytes[k * size + j];
						outs.push_back('{KIND_ELEMENT, rp_id, 3'(k), word, ST_OK,
							LINK_NONE, 1'b0});
					end
					rp_filled = 0;
					rp_phase = PH_ID;
					// The event type is checked only after its element has gone out.
					if (rp_id == IdEventType) begin
						if (rp_bytes[0] != event_type)
							flag_error(ST_EVTYPE);
					end else if (rp_id == IdAclHandle) begin
						rp_link = LINK_ACL;
					end else if (rp_id == IdScoHandle) begin
						rp_link = LINK_SCO;
					end
				end else if (fin) begin
					flag_error(ST_TRUNC);
				end
			end
			default: ;
		endcase
		if (fin) begin
			outs.push_back('{KIND_STATUS, 8'h00, 3'd0, 32'd0, rp_error, rp_link, 1'b0});
			clear_parse();
		end
		if (outs.size() > 0)
			outs[outs.size() - 1].last = 1'b1;
	endfunction

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int idle_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return 0;
		else if (roll < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] value_byte();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 8)
			return 8'h00;
		else if (roll < 16)
			return 8'hff;
		else
			return 8'($urandom_range(0, 255));
	endfunction

	// Any id from the table, with every group of ids equally likely.
	function automatic logic [7:0] known_id();
		case ($urandom_range(0, 6))
			0: return IdEventType;
			1: return IdAclHandle;
			2: return IdScoHandle;
			3: return 8'($urandom_range(IdWordFirst, IdWordLast));
			4: return 8'($urandom_range(IdScoFirst, IdScoLast));
			5: return 8'($urandom_range(IdMultiFirst, IdMultiLast));
			default: return 8'($urandom_range(IdTailFirst, IdTailLast));
		endcase
	endfunction

	function automatic logic [7:0] unknown_id();
		logic [7:0] id;
		int unsigned size, count;
		do begin
			id = 8'($urandom_range(0, 255));
			tlv_shape(id, size, count);
		end while (size != 0);
		return id;
	endfunction

	// Builds one random report. Most reports are well formed with random ids and values, so
	// that the parser gets deep into its TLV states. A few are plain noise, and a few carry a
	// bad sub-opcode, an unknown id, a bad length, a wrong event type or an early end.
	function automatic void compose_report(ref report_byte_t rq[$]);
		int roll, tlvs, cut, i;
		int unsigned size, count;
		logic [7:0] id, len;
		rq.delete();
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			repeat ($urandom_range(1, 8))
				rq.push_back('{8'($urandom_range(0, 255)), 1'b0});
		end else begin
			rq.push_back('{value_byte(), 1'b0});
			rq.push_back('{value_byte(), 1'b0});
			rq.push_back('{(roll < 13) ? 8'($urandom_range(0, 255)) : SubOpcode, 1'b0});
			tlvs = $urandom_range(0, 4);
			repeat (tlvs) begin
				id = ($urandom_range(0, 99) < 4) ? unknown_id() : known_id();
				tlv_shape(id, size, count);
				len = 8'(size * count);
				if ($urandom_range(0, 99) < 4)
					len = 8'($urandom_range(0, 255));
				rq.push_back('{id, 1'b0});
				rq.push_back('{len, 1'b0});
				for (i = 0; i < size * count; i++) begin
					if (id == IdEventType && i == 0 && $urandom_range(0, 99) < 85)
						rq.push_back('{event_type, 1'b0});
					else
						rq.push_back('{value_byte(), 1'b0});
				end
			end
		end
		// Now and then the report stops early, at any byte.
		if (rq.size() > 1 && $urandom_range(0, 99) < 8) begin
			cut = $urandom_range(1, rq.size() - 1);
			while (rq.size() > cut)
				void'(rq.pop_back());
		end
		rq[rq.size() - 1].fin = 1'b1;
	endfunction

	// Offers one byte and waits until the parser takes it. Valid stays high after the
	// request so that back-to-back bytes need no second assignment in one time step.
	task automatic send_byte(input logic [7:0] b, input logic fin, input logic pinned,
			input status_t status, input link_t link);
		int gap;
		parsed_result_t outs[$];
		gap = steady_sender ? 0 : idle_length();
		if (gap > 0) begin
			report_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		report_bus.valid <= 1'b1;
		report_bus.data_byte <= b;
		report_bus.final_byte <= fin;
		@(posedge clk);
		while (!report_bus.ready)
			@(posedge clk);
		// Bytes that land in a report already marked bad do not count as real work.
		if (rp_phase != PH_SKIP)
			parsed_bytes++;
		parse_report_byte(b, fin, outs);
		if (pinned)
			awaited_results.push_back('{KIND_STATUS, 8'h00, 3'd0, 32'd0, status, link, 1'b1});
		else
			foreach (outs[i])
				awaited_results.push_back(outs[i]);
	endtask

	// Lets the parser run dry so that the register can be written while it is idle.
	task automatic drain();
		report_bus.valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_event_type(input logic [7:0] v);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		event_type = v;
	endtask

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			failures++;
		end
	endfunction

	task automatic check_result();
		parsed_result_t want;
		if (awaited_results.size() == 0) begin
			$error("result with no request pending: kind %0d id %0h value %0h",
				result_bus.result_kind, result_bus.subevent_id, result_bus.element_value);
			failures++;
		end else begin
			want = awaited_results.pop_front();
			compare_field("result_kind", want.kind, result_bus.result_kind);
			compare_field("subevent_id", want.id, result_bus.subevent_id);
			compare_field("element_index", want.index, result_bus.element_index);
			compare_field("element_value", want.value, result_bus.element_value);
			compare_field("report_status", want.status, result_bus.report_status);
			compare_field("link_kind", want.link, result_bus.link_kind);
			compare_field("is_last", want.last, result_bus.is_last);
		end
	endtask

	// Result side. Ready runs in random stretches of high and low. Once, after a few dozen
	// results, it holds off for a long time so that the job queue fills and the report
	// channel has to stall while bytes keep being offered.
	initial begin : result_sink
		int stall_left, run_left, seen;
		bit held;
		stall_left = 0;
		run_left = 0;
		seen = 0;
		held = 1'b0;
		result_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (result_bus.valid && result_bus.ready) begin
				check_result();
				seen++;
				if (seen == 30 && !held) begin
					held = 1'b1;
					stall_left = 250;
					run_left = 0;
				end
			end
			if (stall_left == 0 && run_left == 0) begin
				if ($urandom_range(0, 9) < 7)
					run_left = $urandom_range(1, 40);
				else
					stall_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
						: $urandom_range(1, 3);
			end
			if (stall_left > 0) begin
				result_bus.ready <= 1'b0;
				stall_left--;
			end else begin
				result_bus.ready <= 1'b1;
				run_left--;
			end
		end
	end

	// Report side: reset, the directed table under the reset event type, then random
	// reports under several event type settings, the two extremes among them.
	initial begin : report_source
		report_byte_t rq[$];
		logic [7:0] settings [4];
		int start;
		report_bus.valid <= 1'b0;
		report_bus.data_byte <= 8'h00;
		report_bus.final_byte <= 1'b0;
		cfg_wen <= 1'b0;
		cfg_wdata <= 8'h00;
		event_type = EvTypeReset;
		clear_parse();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (ReportScript[i])
			send_byte(ReportScript[i].data, ReportScript[i].fin, ReportScript[i].pinned,
				ReportScript[i].status, ReportScript[i].link);
		drain();

		settings = '{8'h00, 8'hff, 8'($urandom_range(1, 254)), EvTypeReset};
		foreach (settings[k]) begin
			write_event_type(settings[k]);
			start = parsed_bytes;
			while (parsed_bytes - start < 55) begin
				compose_report(rq);
				// Some reports go out with no gaps at all between their bytes.
				steady_sender = ($urandom_range(0, 9) < 3);
				foreach (rq[i])
					send_byte(rq[i].data, rq[i].fin, 1'b0, ST_OK, LINK_NONE);
			end
			drain();
		end

		if (failures == 0 && awaited_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Far beyond the slowest correct run, long stalls and the hold-off included.
	initial begin : watchdog
		#5000000;
		$display("status: fail");
		$finish;
	end

endmodule
